### src/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants for the motor feedback decoder with multi-turn
// angle unwrap.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int GROUPS_DEF = 2;
  localparam int SLOTS_DEF  = 8;

  localparam int COUNTS_PER_TURN = 8191;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ID_GROUP0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ID_GROUP1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_COUNT_GROUP0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_COUNT_GROUP1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD     = 3'd4;

  localparam logic [10:0] BASE_ID_GROUP0_RST     = 11'd512;
  localparam logic [10:0] BASE_ID_GROUP1_RST     = 11'd516;
  localparam logic [3:0]  MOTOR_COUNT_GROUP0_RST = 4'd8;
  localparam logic [3:0]  MOTOR_COUNT_GROUP1_RST = 4'd8;
  localparam logic [12:0] WRAP_THRESHOLD_RST     = 13'd6552;

  typedef struct packed {
    logic        group;
    logic [10:0] std_id;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         slot;
    logic [15:0]        raw_angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         temperature;
    logic signed [31:0] turns;
    logic signed [47:0] angle_total;
  } out_t;

  typedef struct packed {
    logic [10:0] base_id_group0;
    logic [10:0] base_id_group1;
    logic [3:0]  motor_count_group0;
    logic [3:0]  motor_count_group1;
    logic [12:0] wrap_threshold;
  } cfg_t;

  // One slot's stored unwrap state.
  typedef struct packed {
    logic [31:0] turns;
    logic [15:0] angle;
  } entry_t;

endpackage

### src/mfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mfd_cfg_regs
// Configuration register file: base IDs, motor counts and wrap threshold.
// ----------------------------------------------------------------------------
module mfd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mfd_pkg::cfg_t                  cfg
);

  mfd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_id_group0     <= mfd_pkg::BASE_ID_GROUP0_RST;
      cfg_r.base_id_group1     <= mfd_pkg::BASE_ID_GROUP1_RST;
      cfg_r.motor_count_group0 <= mfd_pkg::MOTOR_COUNT_GROUP0_RST;
      cfg_r.motor_count_group1 <= mfd_pkg::MOTOR_COUNT_GROUP1_RST;
      cfg_r.wrap_threshold     <= mfd_pkg::WRAP_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfd_pkg::REG_BASE_ID_GROUP0:     cfg_r.base_id_group0     <= cfg_wdata[10:0];
        mfd_pkg::REG_BASE_ID_GROUP1:     cfg_r.base_id_group1     <= cfg_wdata[10:0];
        mfd_pkg::REG_MOTOR_COUNT_GROUP0: cfg_r.motor_count_group0 <= cfg_wdata[3:0];
        mfd_pkg::REG_MOTOR_COUNT_GROUP1: cfg_r.motor_count_group1 <= cfg_wdata[3:0];
        mfd_pkg::REG_WRAP_THRESHOLD:     cfg_r.wrap_threshold     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### src/mfd_state_mem.sv
// ----------------------------------------------------------------------------
// mfd_state_mem
// Per-slot unwrap state memory with one registered read port, one write port
// and a received flag per entry. An entry never written reads as zero.
// ----------------------------------------------------------------------------
module mfd_state_mem #(
  parameter int ENTRIES = mfd_pkg::GROUPS_DEF * mfd_pkg::SLOTS_DEF,
  parameter int IDX_W   = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output mfd_pkg::entry_t  rd_entry,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  mfd_pkg::entry_t  wr_entry
);

  mfd_pkg::entry_t    mem_r [ENTRIES];
  mfd_pkg::entry_t    rd_data_r;
  logic [ENTRIES-1:0] rcvd_r;
  logic               rd_rcvd_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_idx];
    end
    if (wr_en) begin
      mem_r[wr_idx] <= wr_entry;
    end
  end

  // The received flags double as valid bits for the memory contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcvd_r    <= '0;
      rd_rcvd_r <= 1'b0;
    end else begin
      if (wr_en) begin
        rcvd_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_rcvd_r <= rcvd_r[rd_idx];
      end
    end
  end

  assign rd_entry = rd_rcvd_r ? rd_data_r : '0;

endmodule

### src/mfd_unwrap.sv
// ----------------------------------------------------------------------------
// mfd_unwrap
// Turn wrap detection and multi-turn angle total for one slot update.
// ----------------------------------------------------------------------------
module mfd_unwrap (
  input  mfd_pkg::entry_t    old_entry,
  input  logic [15:0]        angle,
  input  logic [12:0]        wrap_threshold,
  output logic [31:0]        turns_new,
  output logic signed [47:0] angle_total
);

  logic signed [16:0] delta;
  logic signed [16:0] thr;
  logic signed [47:0] turns_ext;
  logic signed [47:0] turns_scaled;

  always_comb begin
    delta = $signed({1'b0, old_entry.angle}) - $signed({1'b0, angle});
    thr   = $signed({4'b0, wrap_threshold});
    if (delta > thr) begin
      turns_new = old_entry.turns + 32'd1;
    end else if (delta < -thr) begin
      turns_new = old_entry.turns - 32'd1;
    end else begin
      turns_new = old_entry.turns;
    end
    // turns * 8191 as (turns << 13) - turns.
    turns_ext    = $signed({{16{turns_new[31]}}, turns_new});
    turns_scaled = (turns_ext <<< 13) - turns_ext;
    angle_total  = turns_scaled + $signed({32'b0, angle});
  end

endmodule

### src/motor_feedback_decode_multiturn_core.sv
// ----------------------------------------------------------------------------
// motor_feedback_decode_multiturn_core
// Motor feedback frame decoder: ID filter, payload unpack and multi-turn
// angle unwrap per motor slot.
// ----------------------------------------------------------------------------
// The block takes one frame word per clock and returns one result word per
// frame from the output register. The sustained rate of one word per cycle,
// while the output side is ready, is set by the single read-modify-write of
// the slot state memory: the slot is read at acceptance, updated in the next
// cycle and written back as the result moves to the output register, with a
// bypass for a word hitting the slot written in the same cycle. Stored state
// is cleared at reset through per-entry received flags, so no clearing pass
// is needed and words are accepted right after reset. Rejected frames return
// a result word with every field zero and leave the state untouched.
module motor_feedback_decode_multiturn_core #(
  parameter int GROUPS = mfd_pkg::GROUPS_DEF,
  parameter int SLOTS  = mfd_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mfd_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mfd_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ENTRIES = GROUPS * SLOTS;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  mfd_pkg::cfg_t cfg;

  mfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Frame check and slot index.
  logic             in_fire;
  logic [10:0]      base_id;
  logic [3:0]       motor_count;
  logic [10:0]      slot_full;
  logic             in_acc;
  logic [IDX_W-1:0] in_idx;

  always_comb begin
    base_id     = in_data.group ? cfg.base_id_group1 : cfg.base_id_group0;
    motor_count = in_data.group ? cfg.motor_count_group1 : cfg.motor_count_group0;
    slot_full   = in_data.std_id - base_id - 11'd1;
    in_acc      = (32'(in_data.group) < GROUPS) &&
                  (in_data.std_id > base_id) &&
                  (slot_full < {7'b0, motor_count}) &&
                  (32'(slot_full) < SLOTS);
    in_idx      = IDX_W'(32'(in_data.group) * SLOTS + 32'(slot_full));
  end

  // Update stage.
  logic             s1_valid_r;
  logic             s1_acc_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [2:0]       s1_slot_r;
  mfd_pkg::in_t     s1_in_r;
  logic             s1_fire;

  logic             hit_r;
  mfd_pkg::entry_t  byp_r;
  mfd_pkg::entry_t  rd_entry;
  mfd_pkg::entry_t  old_entry;
  mfd_pkg::entry_t  wr_entry;
  logic             wr_en;

  logic [15:0]        s1_angle;
  logic [31:0]        turns_new;
  logic signed [47:0] angle_total;

  logic          out_valid_r;
  mfd_pkg::out_t out_data_r;
  mfd_pkg::out_t out_nxt;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = s1_fire && s1_acc_r;
  assign s1_angle = {s1_in_r.byte0, s1_in_r.byte1};

  mfd_state_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_idx   (in_idx),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_idx   (s1_idx_r),
    .wr_entry (wr_entry)
  );

  // A word read in the same cycle as a write to its slot sees the old memory
  // contents, so the written entry is carried along instead.
  assign old_entry = hit_r ? byp_r : rd_entry;

  mfd_unwrap u_unwrap (
    .old_entry      (old_entry),
    .angle          (s1_angle),
    .wrap_threshold (cfg.wrap_threshold),
    .turns_new      (turns_new),
    .angle_total    (angle_total)
  );

  assign wr_entry = '{turns: turns_new, angle: s1_angle};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        hit_r      <= wr_en && in_acc && (s1_idx_r == in_idx);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
        hit_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_acc_r  <= in_acc;
      s1_idx_r  <= in_idx;
      s1_slot_r <= slot_full[2:0];
      s1_in_r   <= in_data;
      byp_r     <= wr_entry;
    end
  end

  always_comb begin
    out_nxt = '0;
    if (s1_acc_r) begin
      out_nxt.accepted    = 1'b1;
      out_nxt.slot        = s1_slot_r;
      out_nxt.raw_angle   = s1_angle;
      out_nxt.speed       = $signed({s1_in_r.byte2, s1_in_r.byte3});
      out_nxt.current     = $signed({s1_in_r.byte4, s1_in_r.byte5});
      out_nxt.temperature = s1_in_r.byte6;
      out_nxt.turns       = $signed(turns_new);
      out_nxt.angle_total = angle_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_bypass_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> s1_valid_r && s1_acc_r)
    else $error("bypass flag set without an accepted word in the update stage");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> out_data == '0)
    else $error("rejected result word carries nonzero fields");

  a_total_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |->
      out_data.angle_total == 48'($signed(out_data.turns)) * 48'd8191 +
                              48'(out_data.raw_angle))
    else $error("angle total does not match turns and raw angle");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled while the update stage is empty");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor feedback decoder with multi-turn unwrap.
// Frames are pushed through the valid/ready input with random gaps. Each
// result word is compared field by field against a behavioral decoder that
// keeps its own copy of the ID filter settings and the per-slot angle state.
// The run covers several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import mfd_pkg::*;

  localparam int ENTRIES     = GROUPS_DEF * SLOTS_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int REPORT_MAX  = 10;

  // Indexes past the last register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  motor_feedback_decode_multiturn_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    in_t  frame;
    bit   typed;
    out_t want;
  } row_t;

  cfg_t        regs;
  logic [15:0] prev_angle [ENTRIES];
  logic [31:0] turn_ctr [ENTRIES];
  out_t        awaited_feedback [$];
  row_t        script [$];
  int          fault_count = 0;
  int          frames_sent = 0;
  bit          calm_send   = 1'b0;

  // Filters the ID, unpacks the payload and advances the slot's turn counter.
  function automatic out_t decode_feedback(in_t f);
    logic [10:0] base;
    logic [3:0]  cnt;
    logic [10:0] slot;
    logic [15:0] ang;
    int          idx;
    int          diff;
    longint      total;
    out_t        r;
    r    = '0;
    base = f.group ? regs.base_id_group1 : regs.base_id_group0;
    cnt  = f.group ? regs.motor_count_group1 : regs.motor_count_group0;
    if (f.std_id <= base) return r;
    slot = f.std_id - base - 11'd1;
    if (slot >= cnt || slot >= SLOTS_DEF) return r;
    idx  = int'(f.group) * SLOTS_DEF + int'(slot);
    ang  = {f.byte0, f.byte1};
    diff = int'(prev_angle[idx]) - int'(ang);
    if (diff > int'(regs.wrap_threshold)) begin
      turn_ctr[idx] = turn_ctr[idx] + 32'd1;
    end else if (diff < -int'(regs.wrap_threshold)) begin
      turn_ctr[idx] = turn_ctr[idx] - 32'd1;
    end
    prev_angle[idx] = ang;
    total = longint'($signed(turn_ctr[idx])) * COUNTS_PER_TURN + longint'(ang);
    r.accepted    = 1'b1;
    r.slot        = slot[2:0];
    r.raw_angle   = ang;
    r.speed       = {f.byte2, f.byte3};
    r.current     = {f.byte4, f.byte5};
    r.temperature = f.byte6;
    r.turns       = turn_ctr[idx];
    r.angle_total = total[47:0];
    return r;
  endfunction

  function automatic in_t frame_of(bit grp, int id, logic [15:0] ang, logic [15:0] spd,
                                   logic [15:0] cur, logic [7:0] tmp);
    in_t f;
    f.group  = grp;
    f.std_id = 11'(id);
    {f.byte0, f.byte1} = ang;
    {f.byte2, f.byte3} = spd;
    {f.byte4, f.byte5} = cur;
    f.byte6  = tmp;
    return f;
  endfunction

  function automatic out_t word_of(int slot, logic [15:0] ang, logic [15:0] spd,
                                   logic [15:0] cur, logic [7:0] tmp, logic [31:0] trn,
                                   logic [47:0] total);
    out_t r;
    r.accepted    = 1'b1;
    r.slot        = 3'(slot);
    r.raw_angle   = ang;
    r.speed       = spd;
    r.current     = cur;
    r.temperature = tmp;
    r.turns       = trn;
    r.angle_total = total;
    return r;
  endfunction

  function automatic cfg_t cfg_of(int b0, int b1, int c0, int c1, int thr);
    cfg_t c;
    c.base_id_group0     = 11'(b0);
    c.base_id_group1     = 11'(b1);
    c.motor_count_group0 = 4'(c0);
    c.motor_count_group1 = 4'(c1);
    c.wrap_threshold     = 13'(thr);
    return c;
  endfunction

  // Random filler above the register's width checks that the upper bits drop.
  function automatic logic [CFG_DATA_W-1:0] padded(logic [CFG_DATA_W-1:0] v, int w);
    logic [CFG_DATA_W-1:0] r;
    r = CFG_DATA_W'($urandom);
    for (int b = 0; b < w; b++) r[b] = v[b];
    return r;
  endfunction

  // Mostly frames aimed at a live slot, some near the ID window edges, some noise.
  function automatic in_t random_frame();
    logic [95:0] noise;
    logic [10:0] base;
    logic [3:0]  cnt;
    int          pick;
    in_t         f;
    noise = {$urandom, $urandom, $urandom};
    f     = noise[$bits(in_t)-1:0];
    base  = f.group ? regs.base_id_group1 : regs.base_id_group0;
    cnt   = f.group ? regs.motor_count_group1 : regs.motor_count_group0;
    pick  = $urandom_range(0, 9);
    if (pick < 7) begin
      f.std_id = base + 11'd1 + 11'($urandom_range(0, (cnt == 0) ? 0 : cnt - 1));
    end else if (pick < 9) begin
      f.std_id = base + 11'($urandom_range(0, cnt + 2)) - 11'd1;
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      {f.byte0, f.byte1} = 16'($urandom_range(0, COUNTS_PER_TURN));
    end else if (pick < 7) begin
      {f.byte0, f.byte1} = 16'($urandom_range(0, 300));
    end else if (pick < 9) begin
      {f.byte0, f.byte1} = 16'($urandom_range(COUNTS_PER_TURN - 300, COUNTS_PER_TURN));
    end
    return f;
  endfunction

  task automatic add_row(in_t f, bit typed, out_t want);
    row_t r;
    r.frame = f;
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endtask

  task automatic send_frame(in_t f, bit typed, out_t want);
    int   gap;
    out_t pred;
    if (frames_sent % 50 == 0) calm_send = ($urandom_range(0, 3) == 0);
    gap = calm_send ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // The decoder still runs on typed rows so that the slot state stays in step.
    pred = decode_feedback(f);
    awaited_feedback.push_back(typed ? want : pred);
    frames_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_BASE_ID_GROUP0:     regs.base_id_group0     = data[10:0];
      REG_BASE_ID_GROUP1:     regs.base_id_group1     = data[10:0];
      REG_MOTOR_COUNT_GROUP0: regs.motor_count_group0 = data[3:0];
      REG_MOTOR_COUNT_GROUP1: regs.motor_count_group1 = data[3:0];
      REG_WRAP_THRESHOLD:     regs.wrap_threshold     = data[12:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_feedback.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic field_check(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      if (fault_count < REPORT_MAX) begin
        $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
      fault_count++;
    end
  endtask

  initial begin : result_side
    int   gap;
    int   taken;
    bit   calm;
    out_t want;
    taken = 0;
    calm  = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (awaited_feedback.size() == 0) begin
        if (fault_count < REPORT_MAX) $display("result word with nothing outstanding");
        fault_count++;
      end else begin
        want = awaited_feedback.pop_front();
        field_check("accepted",    want.accepted,    out_data.accepted);
        field_check("slot",        want.slot,        out_data.slot);
        field_check("raw_angle",   want.raw_angle,   out_data.raw_angle);
        field_check("speed",       want.speed,       out_data.speed);
        field_check("current",     want.current,     out_data.current);
        field_check("temperature", want.temperature, out_data.temperature);
        field_check("turns",       want.turns,       out_data.turns);
        field_check("angle_total", want.angle_total, out_data.angle_total);
      end
      taken++;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    cfg_t plan [4];
    int   plan_items [4];
    regs = cfg_of(BASE_ID_GROUP0_RST, BASE_ID_GROUP1_RST, MOTOR_COUNT_GROUP0_RST,
                  MOTOR_COUNT_GROUP1_RST, WRAP_THRESHOLD_RST);
    for (int i = 0; i < ENTRIES; i++) begin
      prev_angle[i] = '0;
      turn_ctr[i]   = '0;
    end
    // Lowest group 0 base, group 1 shut out by a base at the top, threshold zero.
    plan[0] = cfg_of(0, 2047, 8, 8, 0);
    plan_items[0] = 130;
    // Group 0 count above the slot array, largest threshold.
    plan[1] = cfg_of(100, 2040, 15, 3, 8191);
    plan_items[1] = 110;
    // Group 0 window ends at the top of the ID range, group 1 has no slots.
    plan[2] = cfg_of(2044, 516, 8, 0, 4000);
    plan_items[2] = 110;
    plan[3] = cfg_of(BASE_ID_GROUP0_RST, BASE_ID_GROUP1_RST, MOTOR_COUNT_GROUP0_RST,
                     MOTOR_COUNT_GROUP1_RST, WRAP_THRESHOLD_RST);
    plan_items[3] = 100;

    // Rejections by ID: at the base, far below, above the window, at group 1's base.
    add_row(frame_of(0, 512, 16'h1234, 16'h5678, 16'h9abc, 8'hde), 1'b1, '0);
    add_row(frame_of(0, 0, 16'hffff, 16'hffff, 16'hffff, 8'hff), 1'b1, '0);
    add_row(frame_of(1, 2047, 16'h0001, 16'h0002, 16'h0003, 8'h04), 1'b1, '0);
    add_row(frame_of(1, 516, 16'h0100, 16'h0200, 16'h0300, 8'h40), 1'b1, '0);
    // First frame of a slot compares against an angle of zero.
    add_row(frame_of(0, 513, 16'd0, 16'h7fff, 16'h8000, 8'hff), 1'b1,
            word_of(0, 16'd0, 16'h7fff, 16'h8000, 8'hff, 32'd0, 48'd0));
    add_row(frame_of(0, 520, 16'd8191, 16'h8000, 16'h7fff, 8'h00), 1'b1,
            word_of(7, 16'd8191, 16'h8000, 16'h7fff, 8'h00, 32'hffff_ffff, 48'd0));
    add_row(frame_of(0, 521, 16'h0aaa, 16'h0bbb, 16'h0ccc, 8'h11), 1'b1, '0);
    add_row(frame_of(1, 525, 16'h0ddd, 16'h0eee, 16'h0fff, 8'h22), 1'b1, '0);
    add_row(frame_of(1, 517, 16'd100, 16'h0001, 16'hffff, 8'h33), 1'b0, '0);
    // Angles beyond one turn are taken as they are.
    add_row(frame_of(1, 524, 16'hffff, 16'hfffe, 16'h0001, 8'h44), 1'b0, '0);
    add_row(frame_of(1, 524, 16'd0, 16'h0000, 16'h0000, 8'h55), 1'b0, '0);
    add_row(frame_of(0, 520, 16'd0, 16'h1111, 16'h2222, 8'h66), 1'b0, '0);
    add_row(frame_of(0, 513, 16'd7000, 16'h3333, 16'h4444, 8'h77), 1'b0, '0);
    add_row(frame_of(0, 513, 16'd200, 16'h5555, 16'h6666, 8'h88), 1'b0, '0);
    // A jump of exactly the threshold is no wrap; one more count is.
    add_row(frame_of(0, 513, 16'd6752, 16'h7777, 16'h8888, 8'h99), 1'b0, '0);
    add_row(frame_of(0, 513, 16'd199, 16'h9999, 16'haaaa, 8'hbb), 1'b0, '0);
    add_row(frame_of(1, 523, 16'h5555, 16'haaaa, 16'h5555, 8'haa), 1'b0, '0);
    add_row(frame_of(0, 514, 16'haaaa, 16'h5555, 16'haaaa, 8'h55), 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send_frame(script[i].frame, script[i].typed, script[i].want);
    repeat (200) send_frame(random_frame(), 1'b0, '0);

    for (int p = 0; p < 4; p++) begin
      settle();
      write_reg(REG_BASE_ID_GROUP0, padded(13'(plan[p].base_id_group0), 11));
      write_reg(REG_BASE_ID_GROUP1, padded(13'(plan[p].base_id_group1), 11));
      write_reg(REG_MOTOR_COUNT_GROUP0, padded(13'(plan[p].motor_count_group0), 4));
      write_reg(REG_MOTOR_COUNT_GROUP1, padded(13'(plan[p].motor_count_group1), 4));
      write_reg(REG_WRAP_THRESHOLD, plan[p].wrap_threshold);
      for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
        write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
      end
      cfg_we <= 1'b0;
      repeat (plan_items[p]) send_frame(random_frame(), 1'b0, '0);
    end

    settle();
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
